### hw/rtl/matrix3_inverse_core_defines.svh
// Assertion macros for the 3x3 matrix inverse core.
`ifndef MATRIX3_INVERSE_CORE_DEFINES_SVH
`define MATRIX3_INVERSE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MI3_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MI3_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mi3_pkg.sv
// Shared constants and index helpers for the 3x3 matrix inverse core.
package mi3_pkg;

    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF     = 16;

    // Position of the output flags within tuser.
    localparam int FLAG_SINGULAR  = 0;
    localparam int FLAG_SATURATED = 1;

    // Lower of the two rows/columns that remain once index i is struck out.
    function automatic int other_lo(input int i);
        return (i == 0) ? 1 : 0;
    endfunction

    // Higher of the two remaining rows/columns.
    function automatic int other_hi(input int i);
        return (i == 2) ? 1 : 2;
    endfunction

endpackage

### hw/rtl/matrix3_inverse_core.sv
// 3x3 fixed-point matrix inverse by adjugate: the whole W+8 stage pipeline.
//
// Takes one signed Q(W-F).F matrix per request and returns its inverse with a
// singular and a saturated flag. Six stages form products, cofactors and the
// determinant, one stage sets up the division, then nine restoring dividers
// resolve one quotient bit per stage, and a final register saturates and signs
// the result. One matrix may enter every cycle; a stall on the output freezes
// the whole pipeline, so throughput is one item per cycle when the output
// side is always ready.
`include "matrix3_inverse_core_defines.svh"

module matrix3_inverse_core #(
    parameter int ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH_DEF,
    parameter int FRAC_BITS     = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // in_m00, in_m01, in_m02, in_m10 .. in_m22, each ELEMENT_WIDTH bits
    input  logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // inv_m00, inv_m01, inv_m02, inv_m10 .. inv_m22, each ELEMENT_WIDTH bits
    output logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]       m_tdata,
    // singular, saturated
    output logic [1:0]                                 m_tuser
);
    import mi3_pkg::*;

    localparam int W    = ELEMENT_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;          // cofactor width
    localparam int DW   = 3 * W + 2;      // determinant width
    localparam int RW   = DW + 1;         // trial remainder width
    localparam int NWID = 2 * W + 2 * F;  // dividend width
    localparam int TW   = ((9 * W + 7) / 8) * 8;
    localparam int NS   = 7 + W;          // stages ahead of the output register

    logic adv;
    logic [NS:1] v_reg;
    logic        m_valid_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;

    // ---------------- stage 1: 2x2 products ----------------
    logic signed [W-1:0]  m_in [3][3];
    logic signed [PW-1:0] pa_next [3][3], pa_reg [3][3];
    logic signed [PW-1:0] pb_next [3][3], pb_reg [3][3];
    logic signed [W-1:0]  r0_reg1 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m_in[i][j] = s_tdata[(3*i+j)*W +: W];
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                pa_next[i][j] = PW'(m_in[other_lo(i)][other_lo(j)])
                              * PW'(m_in[other_hi(i)][other_hi(j)]);
                pb_next[i][j] = PW'(m_in[other_lo(i)][other_hi(j)])
                              * PW'(m_in[other_hi(i)][other_lo(j)]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            r0_reg1 <= m_in[0];
        end
    end

    // ---------------- stage 2: signed cofactors ----------------
    logic signed [PW-1:0] c_next [3][3], c2_reg [3][3];
    logic signed [W-1:0]  r0_reg2 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                c_next[i][j] = ((i + j) % 2 == 1) ? pb_reg[i][j] - pa_reg[i][j]
                                                  : pa_reg[i][j] - pb_reg[i][j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c2_reg  <= c_next;
            r0_reg2 <= r0_reg1;
        end
    end

    // ---------------- stage 3: determinant partial products ----------------
    // cofactor split into signed high half and unsigned low half
    logic signed [DW-1:0] dl_next [3], dl_reg [3];
    logic signed [DW-1:0] dh_next [3], dh_reg [3];
    logic signed [PW-1:0] c3_reg [3][3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            dl_next[j] = DW'(r0_reg2[j]) * DW'($signed({1'b0, c2_reg[0][j][W-1:0]}));
            dh_next[j] = DW'(r0_reg2[j]) * DW'($signed(c2_reg[0][j][PW-1:W]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl_reg <= dl_next;
            dh_reg <= dh_next;
            c3_reg <= c2_reg;
        end
    end

    // ---------------- stage 4: recombine halves ----------------
    logic signed [DW-1:0] t_next [3], t_reg [3];
    logic signed [PW-1:0] c4_reg [3][3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            t_next[j] = (dh_reg[j] <<< W) + dl_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg  <= t_next;
            c4_reg <= c3_reg;
        end
    end

    // ---------------- stage 5: determinant ----------------
    logic signed [DW-1:0] det_reg;
    logic signed [PW-1:0] c5_reg [3][3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            det_reg <= t_reg[0] + t_reg[1] + t_reg[2];
            c5_reg  <= c4_reg;
        end
    end

    // ---------------- stage 6: magnitudes and signs ----------------
    // element e = 3*i + j takes the transposed cofactor c[j][i]
    logic [DW-1:0]   dmag_next, dmag6_reg;
    logic            sing6_reg;
    logic [PW-1:0]   cm_next [9], cm_reg [9];
    logic            neg_next [9], neg6_reg [9];

    always_comb begin
        dmag_next = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                cm_next[3*i+j]  = c5_reg[j][i][PW-1] ? PW'(-c5_reg[j][i])
                                                     : PW'(c5_reg[j][i]);
                neg_next[3*i+j] = c5_reg[j][i][PW-1] ^ det_reg[DW-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dmag6_reg <= dmag_next;
            sing6_reg <= (det_reg == '0);
            cm_reg    <= cm_next;
            neg6_reg  <= neg_next;
        end
    end

    // ---------------- stage 7 and divider stages ----------------
    // index 0 holds the set-up stage; index k holds k quotient bits resolved
    logic [DW-1:0] rem_reg  [W+1][9];
    logic [W-1:0]  lo_reg   [W+1][9];
    logic          neg_reg  [W+1][9];
    logic          ovf_reg  [W+1][9];
    logic [DW-1:0] dmag_reg [W+1];
    logic          sing_reg [W+1];

    logic [NWID-1:0] num;
    logic [DW-1:0]   rem0_next [9];
    logic [W-1:0]    lo0_next  [9];
    logic            ovf0_next [9];

    always_comb begin
        for (int e = 0; e < 9; e++) begin
            num           = {cm_reg[e], {(2*F){1'b0}}};
            rem0_next[e]  = DW'(num[NWID-1:W]);
            lo0_next[e]   = num[W-1:0];
            // quotient needs more than W bits
            ovf0_next[e]  = RW'(num[NWID-1:W]) >= RW'(dmag6_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= rem0_next;
            lo_reg[0]   <= lo0_next;
            ovf_reg[0]  <= ovf0_next;
            neg_reg[0]  <= neg6_reg;
            dmag_reg[0] <= dmag6_reg;
            sing_reg[0] <= sing6_reg;
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_div
        logic [RW-1:0] trial [9];
        logic [DW-1:0] rem_next [9];
        logic [W-1:0]  lo_next [9];
        logic          fits;

        always_comb begin
            fits = 1'b0;
            for (int e = 0; e < 9; e++) begin
                trial[e]    = {rem_reg[k-1][e], lo_reg[k-1][e][W-1]};
                fits        = trial[e] >= {1'b0, dmag_reg[k-1]};
                rem_next[e] = fits ? DW'(trial[e] - {1'b0, dmag_reg[k-1]})
                                   : DW'(trial[e]);
                lo_next[e]  = {lo_reg[k-1][e][W-2:0], fits};
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k]  <= rem_next;
                lo_reg[k]   <= lo_next;
                ovf_reg[k]  <= ovf_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                dmag_reg[k] <= dmag_reg[k-1];
                sing_reg[k] <= sing_reg[k-1];
            end
        end
    end

    // ---------------- output register: clip and sign ----------------
    logic [W-1:0] res_next [9];
    logic [8:0]   sat_vec;
    logic [W-1:0] qv;
    logic [TW-1:0] data_next, data_reg;
    logic [1:0]    user_next, user_reg;

    always_comb begin
        data_next = '0;
        for (int e = 0; e < 9; e++) begin
            qv = lo_reg[W][e];
            if (neg_reg[W][e]) begin
                // negative limit magnitude is 2^(W-1)
                sat_vec[e] = ovf_reg[W][e] || (qv[W-1] && (qv[W-2:0] != '0));
                res_next[e] = sat_vec[e] ? {1'b1, {(W-1){1'b0}}} : W'(-qv);
            end else begin
                sat_vec[e] = ovf_reg[W][e] || qv[W-1];
                res_next[e] = sat_vec[e] ? {1'b0, {(W-1){1'b1}}} : qv;
            end
            if (sing_reg[W]) begin
                res_next[e] = '0;
                sat_vec[e]  = 1'b0;
            end
            data_next[e*W +: W] = res_next[e];
        end
        user_next                 = '0;
        user_next[FLAG_SINGULAR]  = sing_reg[W];
        user_next[FLAG_SATURATED] = |sat_vec;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign m_tdata = data_reg;
    assign m_tuser = user_reg;

    // ---------------- valid chain ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v_reg       <= {v_reg[NS-1:1], s_tvalid};
            m_valid_reg <= v_reg[NS];
        end
    end

    // ---------------- assertions ----------------
    `MI3_ASSERT_IMP(a_singular_zero,
        m_tvalid && m_tuser[FLAG_SINGULAR],
        (m_tdata == '0) && !m_tuser[FLAG_SATURATED],
        "singular result carries non-zero data or saturation")
    `MI3_ASSERT_NXT(a_stall_freezes, !s_tready, $stable(v_reg),
        "pipeline valids moved during output stall")
    `MI3_ASSERT_IMP(a_sing_det_zero, sing_reg[W], dmag_reg[W] == '0,
        "singular flag with non-zero determinant")

endmodule

### dv/tb.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse core.
module tb;
    import mi3_pkg::*;

    localparam int EW = ELEMENT_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int DW = ((9*EW+7)/8)*8;
    localparam int LATENCY = EW + 8;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [DW-1:0] elems;
        logic          singular;
        logic          saturated;
    } inverse_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic [1:0]    m_tuser;

    inverse_t expected_inverses[$];
    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    longint cycle_count = 0;

    matrix3_inverse_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Exact adjugate inverse: cofactors 64 bit, determinant and quotient 128 bit.
    function automatic inverse_t invert_matrix(input logic [DW-1:0] mat);
        logic signed [63:0]  m[3][3];
        logic signed [63:0]  cof[3][3];
        logic signed [127:0] det, cw;
        logic [127:0] dmag, num, quo, lim;
        logic dneg, neg;
        inverse_t r;
        int r1, r2, k1, k2;
        r = '0;
        for (int i = 0; i < 9; i++)
            m[i/3][i%3] = 64'(signed'(mat[i*EW +: EW]));
        for (int i = 0; i < 3; i++) begin
            r1 = (i == 0) ? 1 : 0; r2 = (i == 2) ? 1 : 2;
            for (int j = 0; j < 3; j++) begin
                k1 = (j == 0) ? 1 : 0; k2 = (j == 2) ? 1 : 2;
                cof[i][j] = m[r1][k1]*m[r2][k2] - m[r1][k2]*m[r2][k1];
                if ((i + j) % 2) cof[i][j] = -cof[i][j];
            end
        end
        det = 0;
        for (int j = 0; j < 3; j++) det += 128'(m[0][j]) * 128'(cof[0][j]);
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        dneg = det < 0;
        dmag = dneg ? -det : det;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                cw   = 128'(cof[j][i]);
                neg  = (cw < 0) != dneg;
                num  = (cw < 0 ? -cw : cw) << (2*FB);
                quo  = num / dmag;
                lim  = neg ? (128'd1 << (EW-1)) : (128'd1 << (EW-1)) - 1;
                if (quo > lim) begin
                    quo = lim;
                    r.saturated = 1'b1;
                end
                r.elems[(i*3+j)*EW +: EW] = neg ? EW'(-quo) : EW'(quo);
            end
        return r;
    endfunction

    // valid stays high between back-to-back requests; it drops only on idle cycles
    task automatic send_matrix(input logic [DW-1:0] mat);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_inverses.push_back(invert_matrix(mat));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_inverses.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [DW-1:0] pack_matrix(input logic signed [EW-1:0] e[9]);
        logic [DW-1:0] v;
        v = '0;
        for (int i = 0; i < 9; i++) v[i*EW +: EW] = e[i];
        return v;
    endfunction

    function automatic logic [EW-1:0] random_element();
        case ($urandom_range(5))
            0: return $urandom;
            1: return EW'(signed'($urandom_range(131072)) - 65536);
            2: return EW'(signed'($urandom_range(8388608)) - 4194304);
            3: return EW'($urandom) >>> $urandom_range(EW-1);
            4: return {1'($urandom_range(1)), {(EW-1){$urandom_range(1) == 1}}};
            default: return EW'(signed'($urandom_range(6)) - 3) << FB;
        endcase
    endfunction

    function automatic logic [DW-1:0] random_matrix();
        logic signed [EW-1:0] e[9];
        for (int i = 0; i < 9; i++) e[i] = random_element();
        case ($urandom_range(7))
            0: for (int j = 0; j < 3; j++) e[6+j] = e[j];          // repeated row
            1: for (int j = 0; j < 3; j++) e[3+j] = '0;            // zero row
            2: begin
                for (int i = 0; i < 9; i++) e[i] = '0;             // diagonal
                for (int i = 0; i < 3; i++) e[i*4] = random_element();
            end
            default: ;
        endcase
        return pack_matrix(e);
    endfunction

    // Result checker.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_inverses.size() == 0) begin
                $display("%0t: unexpected result %h / %b", $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                inverse_t e;
                e = expected_inverses.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_tdata[i*EW +: EW] !== e.elems[i*EW +: EW]) begin
                        $display("%0t: element %0d expected %h actual %h", $time, i,
                                 e.elems[i*EW +: EW], m_tdata[i*EW +: EW]);
                        error_count++;
                    end
                if (m_tuser[FLAG_SINGULAR] !== e.singular) begin
                    $display("%0t: singular expected %b actual %b", $time,
                             e.singular, m_tuser[FLAG_SINGULAR]);
                    error_count++;
                end
                if (m_tuser[FLAG_SATURATED] !== e.saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             e.saturated, m_tuser[FLAG_SATURATED]);
                    error_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("matrix3_inverse_core regression: fail");
            $finish;
        end
    end

    always @(posedge aclk)
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    task automatic test_directed();
        logic signed [EW-1:0] e[9];
        logic signed [EW-1:0] one;
        one = 1 <<< FB;
        // identity and scaled identity
        e = '{one, 0, 0, 0, one, 0, 0, 0, one};            send_matrix(pack_matrix(e));
        e = '{-one, 0, 0, 0, 2*one, 0, 0, 0, one/2};       send_matrix(pack_matrix(e));
        // all zero, all ones, all minimum: singular
        e = '{default: 0};                                  send_matrix(pack_matrix(e));
        e = '{default: {EW{1'b1}}};                         send_matrix(pack_matrix(e));
        e = '{default: {1'b1, {(EW-1){1'b0}}}};             send_matrix(pack_matrix(e));
        // extremes on the diagonal
        e = '{{1'b0, {(EW-1){1'b1}}}, 0, 0, 0, {1'b0, {(EW-1){1'b1}}}, 0, 0, 0,
              {1'b1, {(EW-1){1'b0}}}};                      send_matrix(pack_matrix(e));
        e = '{{1'b1, {(EW-1){1'b0}}}, 0, 0, 0, {1'b1, {(EW-1){1'b0}}}, 0, 0, 0,
              {1'b1, {(EW-1){1'b0}}}};                      send_matrix(pack_matrix(e));
        // tiny determinant: saturation both ways
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                   send_matrix(pack_matrix(e));
        e = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};                  send_matrix(pack_matrix(e));
        e = '{one, one, 0, 0, 1, 0, 0, 0, one};             send_matrix(pack_matrix(e));
        // non-symmetric: catches a transposed adjugate
        e = '{one, 2*one, 3*one, 0, one, 4*one, 5*one, 6*one, 0}; send_matrix(pack_matrix(e));
        e = '{2*one, -one, 0, -one, 2*one, -one, 0, -one, 2*one}; send_matrix(pack_matrix(e));
        // permutation
        e = '{0, one, 0, 0, 0, one, one, 0, 0};             send_matrix(pack_matrix(e));
        wait_drained();
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int n = 0; n < count; n++) send_matrix(random_matrix());
    endtask

    task automatic test_pause_drain();
        for (int n = 0; n < 20; n++) send_matrix(random_matrix());
        wait_drained();
        for (int n = 0; n < 20; n++) send_matrix(random_matrix());
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(450, 0, 0);
        test_random(400, 62, 0);
        test_random(400, 0, 62);
        test_random(400, 21, 21);
        test_pause_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0)
            $display("matrix3_inverse_core regression: pass");
        else
            $display("matrix3_inverse_core regression: fail");
        $finish;
    end
endmodule
